// File: sv/eoc_pkg.sv
// types, constants and order-check functions shared by the elevator order controller
`default_nettype none

package eoc_pkg;

   localparam int FLOOR_COUNT = 4;
   localparam int TOP_FLOOR   = FLOOR_COUNT - 1;
   localparam int HALL_W      = FLOOR_COUNT - 1;
   localparam int FLOOR_W     = 2;
   localparam int TIMER_W     = 4;
   localparam int REQ_W       = 15;
   localparam int RSP_W       = 18;
   localparam int REQ_BYTES_W = 16;
   localparam int RSP_BYTES_W = 24;

   localparam logic [TIMER_W-1:0] DOOR_SECONDS_RESET = 4'd3;

   localparam logic [1:0] MOTOR_STOP = 2'd0;
   localparam logic [1:0] MOTOR_UP   = 2'd1;
   localparam logic [1:0] MOTOR_DOWN = 2'd2;

   localparam logic [1:0] MODE_CODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_CODE_UP    = 2'd1;
   localparam logic [1:0] MODE_CODE_DOWN  = 2'd2;
   localparam logic [1:0] MODE_CODE_EMERG = 2'd3;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_UP    = 4'b0010,
      MODE_DOWN  = 4'b0100,
      MODE_EMERG = 4'b1000
   } mode_type;

   typedef struct packed {
      logic                     second_tick;
      logic [FLOOR_COUNT-1:0]   cab_pressed;
      logic [HALL_W-1:0]        down_pressed;
      logic [HALL_W-1:0]        up_pressed;
      logic                     stop_pressed;
      logic [FLOOR_W-1:0]       floor_index;
      logic                     at_floor;
   } req_type;

   typedef struct packed {
      logic [1:0]               mode_now;
      logic [FLOOR_W-1:0]       floor_shown;
      logic [FLOOR_COUNT-1:0]   cab_lamps;
      logic [HALL_W-1:0]        down_lamps;
      logic [HALL_W-1:0]        up_lamps;
      logic                     stop_lamp;
      logic                     door_lamp;
      logic [1:0]               motor_dir;
   } rsp_type;

   typedef struct packed {
      mode_type                 mode;
      logic [HALL_W-1:0]        up_orders;
      logic [HALL_W-1:0]        down_orders;
      logic [FLOOR_COUNT-1:0]   cab_orders;
      logic [TIMER_W-1:0]       door_timer;
      logic                     homing;
      logic [FLOOR_W-1:0]       held_floor;
   } state_type;

   function automatic logic [1:0] mode_code(mode_type m);
      logic [1:0] c;
      case (m)
         MODE_IDLE:  c = MODE_CODE_IDLE;
         MODE_UP:    c = MODE_CODE_UP;
         MODE_DOWN:  c = MODE_CODE_DOWN;
         MODE_EMERG: c = MODE_CODE_EMERG;
         default:    c = MODE_CODE_IDLE;
      endcase
      return c;
   endfunction

   function automatic logic [TIMER_W-1:0] open_time(logic [TIMER_W-1:0] ds);
      return (ds != '0) ? ds : TIMER_W'(1);
   endfunction

   // calls holds up and cab orders per floor
   function automatic logic clear_above(logic [FLOOR_COUNT-1:0] calls,
                                        logic [FLOOR_W-1:0] f);
      logic res;
      res = 1'b1;
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         if (i >= int'(f) && calls[i]) res = 1'b0;
      end
      return res;
   endfunction

   // calls holds down, up and cab orders per floor
   function automatic logic clear_below(logic [FLOOR_COUNT-1:0] calls,
                                        logic [FLOOR_W-1:0] f);
      logic res;
      res = 1'b1;
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         if (i <= int'(f) && calls[i]) res = 1'b0;
      end
      return res;
   endfunction

   function automatic logic down_calls_above(logic [HALL_W-1:0] down,
                                             logic [FLOOR_W-1:0] f);
      logic res;
      res = 1'b0;
      for (int i = 0; i < HALL_W; i++) begin
         if (i > int'(f) && down[i]) res = 1'b1;
      end
      return res;
   endfunction

   function automatic mode_type idle_pick(logic [HALL_W-1:0] up,
                                          logic [HALL_W-1:0] down,
                                          logic [FLOOR_COUNT-1:0] cab,
                                          logic [FLOOR_W-1:0] fl);
      mode_type m;
      logic     done;
      m    = MODE_IDLE;
      done = 1'b0;
      // hall orders first, lowest floor wins
      for (int i = 0; i < HALL_W; i++) begin
         if (!done) begin
            if (up[i]) begin
               m    = (i < int'(fl)) ? MODE_DOWN : MODE_UP;
               done = 1'b1;
            end else if (down[i]) begin
               m    = (i + 1 < int'(fl)) ? MODE_DOWN : MODE_UP;
               done = 1'b1;
            end
         end
      end
      // a cab order at the current floor picks nothing
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         if (!done && cab[i]) begin
            if (int'(fl) < i) begin
               m    = MODE_UP;
               done = 1'b1;
            end else if (int'(fl) > i) begin
               m    = MODE_DOWN;
               done = 1'b1;
            end
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// File: sv/eoc_step.sv
// next-state and lamp/motor logic for one poll of the elevator inputs
`default_nettype none

module eoc_step (
   input  eoc_pkg::state_type             cur,
   input  eoc_pkg::req_type               req,
   input  logic [eoc_pkg::TIMER_W-1:0]    door_seconds,
   output eoc_pkg::state_type             nxt,
   output eoc_pkg::rsp_type               rsp
);

   localparam int F = eoc_pkg::FLOOR_COUNT;

   logic [F-1:0]                 upx;
   logic [F-1:0]                 dnx;
   logic [F-1:0]                 cab;
   logic [F-1:0]                 bit_cf;
   logic [eoc_pkg::FLOOR_W-1:0]  lf;
   logic [eoc_pkg::FLOOR_W-1:0]  cf;
   logic [1:0]                   motor;
   logic                         door;
   logic                         stop_lamp;

   always_comb begin
      nxt       = cur;
      motor     = eoc_pkg::MOTOR_STOP;
      door      = 1'b0;
      stop_lamp = 1'b0;
      cf        = req.floor_index;
      // per-floor views: upx bit i is up call at floor i, dnx bit i is down call at floor i
      upx       = {1'b0, cur.up_orders};
      dnx       = {cur.down_orders, 1'b0};
      cab       = cur.cab_orders;
      bit_cf    = F'(1) << cf;
      lf        = req.at_floor ? cf : cur.held_floor;
      nxt.held_floor = lf;

      if (req.stop_pressed) begin
         nxt.mode       = eoc_pkg::MODE_EMERG;
         upx            = '0;
         dnx            = '0;
         cab            = '0;
         nxt.door_timer = '0;
         nxt.homing     = 1'b0;
         stop_lamp      = 1'b1;
         door           = req.at_floor;
      end else if (cur.mode == eoc_pkg::MODE_EMERG || cur.homing) begin
         if (req.at_floor) begin
            nxt.mode   = eoc_pkg::MODE_IDLE;
            nxt.homing = 1'b0;
         end else begin
            motor = eoc_pkg::MOTOR_DOWN;
         end
      end else begin
         upx = upx | {1'b0, req.up_pressed};
         dnx = dnx | {req.down_pressed, 1'b0};
         cab = cab | req.cab_pressed;
         if (cur.door_timer != '0) begin
            if (req.second_tick) nxt.door_timer = cur.door_timer - 1'b1;
         end else if (cur.mode == eoc_pkg::MODE_IDLE) begin
            nxt.mode = eoc_pkg::idle_pick(upx[F-2:0], dnx[F-1:1], cab, lf);
         end else begin
            if (req.at_floor) begin
               if (cur.mode == eoc_pkg::MODE_UP) begin
                  if ((upx & bit_cf) != '0) begin
                     upx            = upx & ~bit_cf;
                     cab            = cab & ~bit_cf;
                     nxt.door_timer = eoc_pkg::open_time(door_seconds);
                  end else if ((cab & bit_cf) != '0) begin
                     cab            = cab & ~bit_cf;
                     nxt.door_timer = eoc_pkg::open_time(door_seconds);
                     if (eoc_pkg::clear_above(upx | cab, cf)) nxt.mode = eoc_pkg::MODE_DOWN;
                  end else if ((dnx & bit_cf) != '0 && eoc_pkg::clear_above(upx | cab, cf)) begin
                     if (!eoc_pkg::down_calls_above(dnx[F-1:1], cf)) begin
                        nxt.mode = eoc_pkg::MODE_DOWN;
                     end
                  end else if (eoc_pkg::clear_above(upx | cab, cf) && cab != '0) begin
                     nxt.mode = eoc_pkg::MODE_DOWN;
                  end else if (int'(cf) == eoc_pkg::TOP_FLOOR) begin
                     nxt.mode = eoc_pkg::MODE_DOWN;
                  end
               end else begin
                  if ((dnx & bit_cf) != '0) begin
                     dnx            = dnx & ~bit_cf;
                     cab            = cab & ~bit_cf;
                     nxt.door_timer = eoc_pkg::open_time(door_seconds);
                  end else if ((cab & bit_cf) != '0) begin
                     cab            = cab & ~bit_cf;
                     nxt.door_timer = eoc_pkg::open_time(door_seconds);
                     if (eoc_pkg::clear_below(dnx | upx | cab, cf)) nxt.mode = eoc_pkg::MODE_UP;
                  end else if ((upx & bit_cf) != '0 &&
                               eoc_pkg::clear_below(dnx | upx | cab, cf)) begin
                     nxt.mode = eoc_pkg::MODE_UP;
                  end else if (eoc_pkg::clear_below(dnx | upx | cab, cf) && cab != '0) begin
                     nxt.mode = eoc_pkg::MODE_UP;
                  end else if (cf == '0) begin
                     nxt.mode = eoc_pkg::MODE_UP;
                  end
               end
            end
            if (upx == '0 && dnx == '0 && cab == '0) nxt.mode = eoc_pkg::MODE_IDLE;
         end
         if (nxt.door_timer != '0) begin
            door = 1'b1;
         end else if (nxt.mode == eoc_pkg::MODE_UP) begin
            motor = eoc_pkg::MOTOR_UP;
         end else if (nxt.mode == eoc_pkg::MODE_DOWN) begin
            motor = eoc_pkg::MOTOR_DOWN;
         end
      end

      nxt.up_orders   = upx[F-2:0];
      nxt.down_orders = dnx[F-1:1];
      nxt.cab_orders  = cab;
   end

   always_comb begin
      rsp.motor_dir   = motor;
      rsp.door_lamp   = door;
      rsp.stop_lamp   = stop_lamp;
      rsp.up_lamps    = nxt.up_orders;
      rsp.down_lamps  = nxt.down_orders;
      rsp.cab_lamps   = nxt.cab_orders;
      rsp.floor_shown = nxt.held_floor;
      rsp.mode_now    = eoc_pkg::mode_code(nxt.mode);
   end

endmodule

`default_nettype wire

// File: sv/elevator_order_controller.sv
// top level of the elevator order controller: input register, state, result register
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | req_tdata: sensors, switches, presses, tick
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata: motor, lamps, floor, mode
//  csr     | in  | csr_wr_en             | csr_wr_data: door_seconds
//
// one poll per cycle sustained while rsp is not stalled; a result passes through
// the input register, then the order logic into the result register
// the state loop is one pass of order checks over the four floors
// reset: door_seconds 3, car homing downward, no orders, both stages empty
// a stalled rsp holds the result register; req keeps flowing into the input
// register until it fills

`default_nettype none

module elevator_order_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // at_floor, floor_index[2], stop_pressed, up_pressed[3], down_pressed[3],
   // cab_pressed[4], second_tick, zero pad
   input  logic [eoc_pkg::REQ_BYTES_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // motor_dir[2], door_lamp, stop_lamp, up_lamps[3], down_lamps[3], cab_lamps[4],
   // floor_shown[2], mode_now[2], zero pad
   output logic [eoc_pkg::RSP_BYTES_W-1:0]      rsp_tdata,
   input  logic                                 csr_wr_en,
   input  logic [eoc_pkg::TIMER_W-1:0]          csr_wr_data
);

   logic                          in_valid_ff;
   eoc_pkg::req_type              in_data_ff;
   logic                          out_valid_ff;
   eoc_pkg::rsp_type              out_data_ff;
   eoc_pkg::state_type            state_ff;
   eoc_pkg::state_type            state_in;
   eoc_pkg::rsp_type              rsp_in;
   logic [eoc_pkg::TIMER_W-1:0]   door_seconds_ff;
   logic                          advance;
   logic                          req_xfer;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(eoc_pkg::RSP_BYTES_W - eoc_pkg::RSP_W)'(0), out_data_ff};

   eoc_step u_step (
      .cur          (state_ff),
      .req          (in_data_ff),
      .door_seconds (door_seconds_ff),
      .nxt          (state_in),
      .rsp          (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         door_seconds_ff      <= eoc_pkg::DOOR_SECONDS_RESET;
         state_ff.mode        <= eoc_pkg::MODE_IDLE;
         state_ff.up_orders   <= '0;
         state_ff.down_orders <= '0;
         state_ff.cab_orders  <= '0;
         state_ff.door_timer  <= '0;
         state_ff.homing      <= 1'b1;
         state_ff.held_floor  <= '0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_wr_en) door_seconds_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) in_data_ff  <= eoc_pkg::req_type'(req_tdata[eoc_pkg::REQ_W-1:0]);
      if (advance)  out_data_ff <= rsp_in;
   end

   // stop lamp only ever lit together with emergency mode
   a_stop_mode : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.stop_lamp |-> out_data_ff.mode_now == eoc_pkg::MODE_CODE_EMERG)
      else $error("stop lamp without emergency mode");

   // motor never runs with the door open in normal service
   a_door_motor : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.door_lamp && !out_data_ff.stop_lamp
         |-> out_data_ff.motor_dir == eoc_pkg::MOTOR_STOP)
      else $error("motor running with door open");

   // while homing or in emergency no order may be latched
   a_no_orders : assert property (@(posedge clock) disable iff (reset)
      state_ff.homing || state_ff.mode == eoc_pkg::MODE_EMERG
         |-> state_ff.up_orders == '0 && state_ff.down_orders == '0 &&
             state_ff.cab_orders == '0)
      else $error("orders latched while homing or in emergency");

   // door timer only runs in normal service
   a_timer_mode : assert property (@(posedge clock) disable iff (reset)
      state_ff.door_timer != '0 |-> state_ff.mode != eoc_pkg::MODE_EMERG && !state_ff.homing)
      else $error("door timer running in emergency or homing");

   // a transfer always lands in the input register
   a_in_capture : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> in_valid_ff)
      else $error("accepted item lost from input register");

endmodule

`default_nettype wire

// File: bench/eoc_poll_checker.sv
// checker for the elevator order controller: predicts each poll result and compares
`timescale 1ns / 100ps

module eoc_poll_checker
   import eoc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_BYTES_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_BYTES_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [TIMER_W-1:0]     csr_wr_data,
   output int                     fail_count,
   output int                     pending
);

   // shadow copy of the controller state
   logic [TIMER_W-1:0]     door_secs;
   mode_type               car_mode;
   logic [HALL_W-1:0]      up_calls;
   logic [HALL_W-1:0]      down_calls;
   logic [FLOOR_COUNT-1:0] cab_calls;
   logic [TIMER_W-1:0]     door_left;
   logic                   homing_on;
   logic [FLOOR_W-1:0]     floor_seen;

   rsp_type expected_outputs[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic void reset_car();
      door_secs  = DOOR_SECONDS_RESET;
      car_mode   = MODE_IDLE;
      up_calls   = '0;
      down_calls = '0;
      cab_calls  = '0;
      door_left  = '0;
      homing_on  = 1'b1;
      floor_seen = '0;
   endfunction

   function automatic logic [1:0] mode_to_code(mode_type m);
      case (m)
         MODE_UP:    return MODE_CODE_UP;
         MODE_DOWN:  return MODE_CODE_DOWN;
         MODE_EMERG: return MODE_CODE_EMERG;
         default:    return MODE_CODE_IDLE;
      endcase
   endfunction

   // nothing left at or above floor f for a trip up
   function automatic bit nothing_above(int f);
      for (int i = f; i < FLOOR_COUNT; i++) begin
         if (i != TOP_FLOOR && up_calls[i]) return 1'b0;
         if (cab_calls[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // nothing left at or below floor f for a trip down
   function automatic bit nothing_below(int f);
      for (int i = f; i >= 0; i--) begin
         if (i != 0 && down_calls[i-1]) return 1'b0;
         if (i != TOP_FLOOR && up_calls[i]) return 1'b0;
         if (cab_calls[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit down_hall_above(int f);
      for (int i = f + 1; i < TOP_FLOOR; i++) begin
         if (down_calls[i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void start_door();
      door_left = (door_secs != '0) ? door_secs : TIMER_W'(1);
   endfunction

   function automatic void choose_direction();
      int fl;
      fl = int'(floor_seen);
      // hall calls first, lowest floor wins
      for (int i = 0; i < TOP_FLOOR; i++) begin
         if (up_calls[i]) begin
            car_mode = (i < fl) ? MODE_DOWN : MODE_UP;
            return;
         end
         if (down_calls[i]) begin
            car_mode = (i < fl - 1) ? MODE_DOWN : MODE_UP;
            return;
         end
      end
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         if (cab_calls[i] && fl < i) begin
            car_mode = MODE_UP;
            return;
         end
         if (cab_calls[i] && fl > i) begin
            car_mode = MODE_DOWN;
            return;
         end
      end
   endfunction

   function automatic void serve_going_up(int cf);
      if (cf != TOP_FLOOR && up_calls[cf]) begin
         up_calls[cf]  = 1'b0;
         cab_calls[cf] = 1'b0;
         start_door();
      end else if (cab_calls[cf]) begin
         cab_calls[cf] = 1'b0;
         start_door();
         if (nothing_above(cf)) car_mode = MODE_DOWN;
      end else if (cf != 0 && down_calls[cf-1] && nothing_above(cf)) begin
         if (!down_hall_above(cf)) car_mode = MODE_DOWN;
      end else if (nothing_above(cf) && cab_calls != '0) begin
         car_mode = MODE_DOWN;
      end else if (cf == TOP_FLOOR) begin
         car_mode = MODE_DOWN;
      end
   endfunction

   function automatic void serve_going_down(int cf);
      if (cf != 0 && down_calls[cf-1]) begin
         down_calls[cf-1] = 1'b0;
         cab_calls[cf]    = 1'b0;
         start_door();
      end else if (cab_calls[cf]) begin
         cab_calls[cf] = 1'b0;
         start_door();
         if (nothing_below(cf)) car_mode = MODE_UP;
      end else if (cf != TOP_FLOOR && up_calls[cf] && nothing_below(cf)) begin
         car_mode = MODE_UP;
      end else if (nothing_below(cf) && cab_calls != '0) begin
         car_mode = MODE_UP;
      end else if (cf == 0) begin
         car_mode = MODE_UP;
      end
   endfunction

   function automatic rsp_type predict_car_outputs(req_type p);
      rsp_type    o;
      int         cf;
      logic [1:0] motor;
      logic       door;
      logic       lamp;
      motor = MOTOR_STOP;
      door  = 1'b0;
      lamp  = 1'b0;
      cf    = int'(p.floor_index);
      if (cf > TOP_FLOOR) cf = TOP_FLOOR;
      if (p.at_floor) floor_seen = FLOOR_W'(cf);

      if (p.stop_pressed) begin
         car_mode   = MODE_EMERG;
         up_calls   = '0;
         down_calls = '0;
         cab_calls  = '0;
         door_left  = '0;
         homing_on  = 1'b0;
         lamp       = 1'b1;
         door       = p.at_floor;
      end else if (car_mode == MODE_EMERG || homing_on) begin
         if (p.at_floor) begin
            car_mode  = MODE_IDLE;
            homing_on = 1'b0;
         end else begin
            motor = MOTOR_DOWN;
         end
      end else begin
         up_calls   |= p.up_pressed;
         down_calls |= p.down_pressed;
         cab_calls  |= p.cab_pressed;
         if (door_left != '0) begin
            if (p.second_tick) door_left = door_left - 1'b1;
         end else if (car_mode == MODE_IDLE) begin
            choose_direction();
         end else begin
            if (p.at_floor) begin
               if (car_mode == MODE_UP) serve_going_up(cf);
               else serve_going_down(cf);
            end
            if (up_calls == '0 && down_calls == '0 && cab_calls == '0)
               car_mode = MODE_IDLE;
         end
         if (door_left != '0) door = 1'b1;
         else if (car_mode == MODE_UP) motor = MOTOR_UP;
         else if (car_mode == MODE_DOWN) motor = MOTOR_DOWN;
      end

      o.motor_dir   = motor;
      o.door_lamp   = door;
      o.stop_lamp   = lamp;
      o.up_lamps    = up_calls;
      o.down_lamps  = down_calls;
      o.cab_lamps   = cab_calls;
      o.floor_shown = floor_seen;
      o.mode_now    = mode_to_code(car_mode);
      return o;
   endfunction

   task automatic note_mismatch(input string field, input int want, input int got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         reset_car();
         expected_outputs.delete();
      end else begin
         if (csr_wr_en) door_secs = csr_wr_data;
         if (req_tvalid && req_tready)
            expected_outputs.push_back(predict_car_outputs(req_type'(req_tdata[REQ_W-1:0])));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[RSP_W-1:0]);
            if (expected_outputs.size() == 0) begin
               note_mismatch("unexpected transfer", 0, int'(got));
            end else begin
               want = expected_outputs.pop_front();
               if (got.motor_dir !== want.motor_dir)
                  note_mismatch("motor_dir", want.motor_dir, got.motor_dir);
               if (got.door_lamp !== want.door_lamp)
                  note_mismatch("door_lamp", want.door_lamp, got.door_lamp);
               if (got.stop_lamp !== want.stop_lamp)
                  note_mismatch("stop_lamp", want.stop_lamp, got.stop_lamp);
               if (got.up_lamps !== want.up_lamps)
                  note_mismatch("up_lamps", want.up_lamps, got.up_lamps);
               if (got.down_lamps !== want.down_lamps)
                  note_mismatch("down_lamps", want.down_lamps, got.down_lamps);
               if (got.cab_lamps !== want.cab_lamps)
                  note_mismatch("cab_lamps", want.cab_lamps, got.cab_lamps);
               if (got.floor_shown !== want.floor_shown)
                  note_mismatch("floor_shown", want.floor_shown, got.floor_shown);
               if (got.mode_now !== want.mode_now)
                  note_mismatch("mode_now", want.mode_now, got.mode_now);
            end
         end
      end
      pending = expected_outputs.size();
   end

endmodule

// File: bench/tb_elevator_order_controller.sv
// testbench top for the elevator order controller: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_elevator_order_controller;
   import eoc_pkg::*;

   localparam int LONG_HOLD      = 400;
   localparam int STALE_LIMIT    = 4000;
   localparam int ITEMS_PER_PASS = 150;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_BYTES_W-1:0] req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_BYTES_W-1:0] rsp_tdata;
   logic                   csr_wr_en   = 1'b0;
   logic [TIMER_W-1:0]     csr_wr_data = '0;

   int fail_count;
   int pending;
   bit stall_request = 1'b0;
   bit burst_mode    = 1'b0;
   int car_pos       = 0;   // half-floor steps, even values sit on a sensor

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   elevator_order_controller i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   eoc_poll_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_poll(bit at, int fl, bit stop, int up, int dn, int cab,
                                         bit tick);
      req_type p;
      p.at_floor     = at;
      p.floor_index  = FLOOR_W'(fl);
      p.stop_pressed = stop;
      p.up_pressed   = HALL_W'(up);
      p.down_pressed = HALL_W'(dn);
      p.cab_pressed  = FLOOR_COUNT'(cab);
      p.second_tick  = tick;
      return p;
   endfunction

   // car mostly walks along the shaft so sensor sequences look physical
   function automatic req_type random_poll();
      req_type p;
      int      step;
      if ($urandom_range(0, 99) < 85) begin
         step    = $urandom_range(0, 2) - 1;
         car_pos = car_pos + step;
         if (car_pos < 0) car_pos = 0;
         if (car_pos > 2 * TOP_FLOOR) car_pos = 2 * TOP_FLOOR;
         p.at_floor    = (car_pos % 2) == 0;
         p.floor_index = p.at_floor ? FLOOR_W'(car_pos / 2) : FLOOR_W'($urandom_range(0, 3));
      end else begin
         p.at_floor    = $urandom_range(0, 1);
         p.floor_index = FLOOR_W'($urandom_range(0, 3));
      end
      p.stop_pressed = $urandom_range(0, 99) < 3;
      p.up_pressed   = ($urandom_range(0, 99) < 15) ? HALL_W'($urandom_range(1, 7)) : '0;
      p.down_pressed = ($urandom_range(0, 99) < 15) ? HALL_W'($urandom_range(1, 7)) : '0;
      p.cab_pressed  = ($urandom_range(0, 99) < 15) ? FLOOR_COUNT'($urandom_range(1, 15)) : '0;
      p.second_tick  = $urandom_range(0, 2) == 0;
      return p;
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_poll(input req_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BYTES_W'(p);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_polls();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_door_seconds(input logic [TIMER_W-1:0] value);
      drain_polls();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // result side: random stalls plus one long hold-off on request
   initial begin
      int idle_left;
      idle_left = 0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (stall_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            stall_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (idle_left > 0) begin
            rsp_tready <= 1'b0;
            idle_left--;
         end else begin
            rsp_tready <= 1'b1;
            idle_left = pick_gap();
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int stale;
      stale = 0;
      while (stale < STALE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stale = 0;
         else stale++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [TIMER_W-1:0] door_plan[6];
      req_type            p;
      int                 counted;
      bit                 ignoring;
      bit                 hold_done;
      bit                 pause_done;
      door_plan[0] = 4'd0;
      door_plan[1] = 4'd15;
      door_plan[2] = 4'd1;
      door_plan[3] = DOOR_SECONDS_RESET;
      door_plan[4] = TIMER_W'($urandom_range(1, 14));
      door_plan[5] = TIMER_W'($urandom_range(0, 15));
      hold_done    = 1'b0;
      pause_done   = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_door_seconds(4'd2);
      // homing, a full trip up and back, stop handling, own-floor cab call
      send_poll(make_poll(0, 3, 0, 0, 0, 0, 0));
      send_poll(make_poll(1, 0, 0, 7, 7, 15, 1));
      send_poll(make_poll(1, 0, 0, 0, 0, 4'b1000, 0));
      send_poll(make_poll(0, 1, 0, 0, 0, 0, 1));
      send_poll(make_poll(1, 1, 0, 0, 3'b010, 0, 0));
      send_poll(make_poll(1, 2, 0, 0, 0, 0, 0));
      send_poll(make_poll(1, 3, 0, 0, 0, 0, 0));
      send_poll(make_poll(1, 3, 0, 0, 0, 0, 1));
      send_poll(make_poll(1, 3, 0, 0, 0, 0, 1));
      send_poll(make_poll(1, 2, 0, 0, 0, 0, 0));
      send_poll(make_poll(1, 2, 0, 7, 0, 15, 1));
      send_poll(make_poll(1, 2, 0, 0, 0, 0, 1));
      send_poll(make_poll(1, 2, 1, 7, 7, 15, 0));
      send_poll(make_poll(0, 1, 1, 0, 0, 0, 1));
      send_poll(make_poll(0, 1, 0, 7, 7, 15, 0));
      send_poll(make_poll(1, 1, 0, 0, 0, 0, 0));
      send_poll(make_poll(1, 1, 0, 0, 0, 4'b0010, 0));
      send_poll(make_poll(1, 1, 0, 3'b001, 0, 0, 0));
      send_poll(make_poll(0, 0, 0, 0, 0, 0, 0));
      send_poll(make_poll(1, 0, 0, 0, 0, 0, 1));
      send_poll(make_poll(1, 3, 0, 7, 7, 15, 1));
      send_poll(make_poll(1, 3, 1, 7, 7, 15, 1));
      send_poll(make_poll(0, 0, 0, 0, 0, 0, 0));
      send_poll(make_poll(1, 0, 0, 0, 0, 0, 0));

      for (int pass = 0; pass < 6; pass++) begin
         write_door_seconds(door_plan[pass]);
         burst_mode = (pass == 2);
         counted    = 0;
         ignoring   = 1'b0;
         while (counted < ITEMS_PER_PASS) begin
            if (pass == 1 && counted == 40 && !hold_done) begin
               stall_request = 1'b1;
               hold_done     = 1'b1;
            end
            if (pass == 3 && counted == 80 && !pause_done) begin
               drain_polls();
               pause_done = 1'b1;
            end
            p = random_poll();
            send_poll(p);
            // polls during a stop or the descent after it are ignored by the car
            if (!ignoring && !p.stop_pressed) counted++;
            ignoring = p.stop_pressed || (ignoring && !p.at_floor);
         end
      end
      burst_mode = 1'b0;

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
